// ----- rtl/rpf_pkg.sv -----
// Shared types and constants of the ring packet forwarder.
package rpf_pkg;

  // Default widths handed to the top-level parameters
  localparam int unsigned DATA_WIDTH_DEF   = 64;
  localparam int unsigned NODE_ID_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned KEEP_W  = 8;
  localparam int unsigned DEST_W  = 8;
  localparam int unsigned COUNT_W = 10;

  // Reset and forced values
  localparam logic [LIMIT_W-1:0] SEND_LIMIT_RST = LIMIT_W'(32);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [KEEP_W-1:0]  KEEP_ALL       = {KEEP_W{1'b1}};
  localparam logic [DEST_W-1:0]  FWD_DEST       = DEST_W'(1);

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // What the back end does with one queued item
  typedef enum logic [1:0] {
    CLS_IDLE,   // nothing taken, result is all zero
    CLS_OWN,    // own packet returned: update copy only
    CLS_FWD,    // foreign packet: update copy and forward
    CLS_LOCAL   // local beat sent toward the ring
  } beat_cls_t;

  // Control part of a queued item
  typedef struct packed {
    beat_cls_t         cls;
    logic              last;
    logic [KEEP_W-1:0] keep;
    logic [DEST_W-1:0] dest;
  } beat_ctrl_t;

endpackage

// ----- rtl/ring_packet_forwarder.sv -----
// Ring packet forwarder top level: front end, item queue and back end.
// An accepted item is written to a queue entry and then loaded into the output register, where its result is valid.
// Throughput: 1 item per cycle; in_stall rises only when the 2-entry queue is full,
//   which happens only while out_stall holds the output register.
// Reset: synchronous, active low; first-beat phase, node id all ones, in-flight count 0,
//   send limit 32, queue and output register empty.
module ring_packet_forwarder import rpf_pkg::*; #(
  parameter int unsigned DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int unsigned NODE_ID_BITS = NODE_ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_net_valid,
  input  logic [DATA_WIDTH-1:0] in_net_data,
  input  logic                  in_net_last,
  input  logic [KEEP_W-1:0]     in_net_keep,
  input  logic [DEST_W-1:0]     in_net_dest,
  input  logic                  in_local_valid,
  input  logic [DATA_WIDTH-1:0] in_local_data,
  input  logic                  in_local_last,
  input  logic [KEEP_W-1:0]     in_local_keep,
  input  logic [DEST_W-1:0]     in_local_dest,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_net_taken,
  output logic                  out_local_taken,
  output logic                  out_update_valid,
  output logic [DATA_WIDTH-1:0] out_update_data,
  output logic                  out_update_last,
  output logic [KEEP_W-1:0]     out_update_keep,
  output logic [DEST_W-1:0]     out_update_dest,
  output logic                  out_out_valid,
  output logic [DATA_WIDTH-1:0] out_out_data,
  output logic                  out_out_last,
  output logic [KEEP_W-1:0]     out_out_keep,
  output logic [DEST_W-1:0]     out_out_dest
);

  logic                  push;
  beat_ctrl_t            push_ctrl;
  logic [DATA_WIDTH-1:0] push_data;
  logic                  pop;
  logic                  q_full;
  logic                  q_empty;
  beat_ctrl_t            head_ctrl;
  logic [DATA_WIDTH-1:0] head_data;

  // Accept and classify
  rpf_front #(
    .DATA_WIDTH   (DATA_WIDTH),
    .NODE_ID_BITS (NODE_ID_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_net_valid   (in_net_valid),
    .in_net_data    (in_net_data),
    .in_net_last    (in_net_last),
    .in_net_keep    (in_net_keep),
    .in_net_dest    (in_net_dest),
    .in_local_valid (in_local_valid),
    .in_local_data  (in_local_data),
    .in_local_last  (in_local_last),
    .in_local_keep  (in_local_keep),
    .in_local_dest  (in_local_dest),
    .q_full         (q_full),
    .push           (push),
    .push_ctrl      (push_ctrl),
    .push_data      (push_data)
  );

  // Decoupling queue
  rpf_queue #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ctrl (push_ctrl),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_ctrl (head_ctrl),
    .head_data (head_data)
  );

  // Format and deliver results
  rpf_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head_ctrl        (head_ctrl),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_net_taken    (out_net_taken),
    .out_local_taken  (out_local_taken),
    .out_update_valid (out_update_valid),
    .out_update_data  (out_update_data),
    .out_update_last  (out_update_last),
    .out_update_keep  (out_update_keep),
    .out_update_dest  (out_update_dest),
    .out_out_valid    (out_out_valid),
    .out_out_data     (out_out_data),
    .out_out_last     (out_out_last),
    .out_out_keep     (out_out_keep),
    .out_out_dest     (out_out_dest)
  );

endmodule

// ----- rtl/rpf_front.sv -----
// Front end: accepts items, runs the packet phase machine and classifies each item.
module rpf_front import rpf_pkg::*; #(
  parameter int unsigned DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int unsigned NODE_ID_BITS = NODE_ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_net_valid,
  input  logic [DATA_WIDTH-1:0] in_net_data,
  input  logic                  in_net_last,
  input  logic [KEEP_W-1:0]     in_net_keep,
  input  logic [DEST_W-1:0]     in_net_dest,
  input  logic                  in_local_valid,
  input  logic [DATA_WIDTH-1:0] in_local_data,
  input  logic                  in_local_last,
  input  logic [KEEP_W-1:0]     in_local_keep,
  input  logic [DEST_W-1:0]     in_local_dest,
  input  logic                  q_full,
  output logic                  push,
  output beat_ctrl_t            push_ctrl,
  output logic [DATA_WIDTH-1:0] push_data
);

  typedef enum logic [1:0] {
    PH_FIRST,   // waiting for a first beat
    PH_SAME,    // rest of an own packet, dropped
    PH_OTHER,   // rest of a foreign packet, forwarded
    PH_SEND     // rest of a local packet being sent
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [NODE_ID_BITS-1:0] own_id_r, own_id_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic [LIMIT_W-1:0]      send_limit_r;
  beat_cls_t               cls;
  logic                    accept;
  logic                    id_match;
  logic                    below_limit;

  assign in_stall    = q_full;
  assign accept      = in_valid && !q_full;
  assign push        = accept;
  assign id_match    = (in_net_data[NODE_ID_BITS-1:0] == own_id_r);
  assign below_limit = (count_r < {{(COUNT_W-LIMIT_W){1'b0}}, send_limit_r});

  // Classify the item and work out the next phase, id and count
  always_comb begin
    cls        = CLS_IDLE;
    phase_nxt  = phase_r;
    own_id_nxt = own_id_r;
    count_nxt  = count_r;
    case (phase_r)
      PH_FIRST: begin
        if (in_net_valid) begin
          if (id_match) begin
            cls       = CLS_OWN;
            phase_nxt = PH_SAME;
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
          end else begin
            cls       = CLS_FWD;
            phase_nxt = PH_OTHER;
          end
        end else if (in_local_valid && below_limit) begin
          cls        = CLS_LOCAL;
          phase_nxt  = PH_SEND;
          own_id_nxt = in_local_data[NODE_ID_BITS-1:0];
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      PH_SAME: begin
        if (in_net_valid) begin
          cls = CLS_OWN;
          if (in_net_last) begin
            phase_nxt = PH_FIRST;
          end
        end
      end
      PH_OTHER: begin
        if (in_net_valid) begin
          cls = CLS_FWD;
          if (in_net_last) begin
            phase_nxt = PH_FIRST;
          end
        end
      end
      PH_SEND: begin
        if (in_local_valid) begin
          cls = CLS_LOCAL;
          if (in_local_last) begin
            phase_nxt = PH_FIRST;
          end
        end
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase
  end

  // Payload of the queued item: the local beat when sending, else the network beat
  always_comb begin
    push_ctrl.cls = cls;
    if (cls == CLS_LOCAL) begin
      push_ctrl.last = in_local_last;
      push_ctrl.keep = in_local_keep;
      push_ctrl.dest = in_local_dest;
      push_data      = in_local_data;
    end else begin
      push_ctrl.last = in_net_last;
      push_ctrl.keep = in_net_keep;
      push_ctrl.dest = in_net_dest;
      push_data      = in_net_data;
    end
  end

  // Phase, node id, in-flight count and the send limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      own_id_r     <= {NODE_ID_BITS{1'b1}};
      count_r      <= '0;
      send_limit_r <= SEND_LIMIT_RST;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        own_id_r <= own_id_nxt;
        count_r  <= count_nxt;
      end
      if (cfg_wr_en) begin
        send_limit_r <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTHESIS
  // A new local send raises the count by one unless it is saturated
  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_FIRST && cls == CLS_LOCAL && count_r != COUNT_MAX)
      |=> count_r == $past(count_r) + 1'b1)
    else $error("in-flight count did not rise on a local send");

  // While a local packet is being sent no network beat is taken
  a_send_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_SEND) |-> (cls == CLS_LOCAL || cls == CLS_IDLE))
    else $error("network beat taken during a local send");

  // A returned own first beat leads into the drop phase
  a_own_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_FIRST && cls == CLS_OWN) |=> phase_r == PH_SAME)
    else $error("own packet did not enter the drop phase");
`endif

endmodule

// ----- rtl/rpf_queue.sv -----
// Short register queue between the front and back ends.
module rpf_queue import rpf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  beat_ctrl_t            push_ctrl,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  empty,
  output beat_ctrl_t            head_ctrl,
  output logic [DATA_WIDTH-1:0] head_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

  beat_ctrl_t            ctrl_q [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0] data_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_DEPTH);
  assign empty     = (cnt_r == '0);
  assign head_ctrl = ctrl_q[rd_ptr_r];
  assign head_data = data_q[rd_ptr_r];

  // Pointer and fill level updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_q[wr_ptr_r] <= push_ctrl;
      data_q[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // Never popped while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  // Never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue pushed while full");

  // Fill level tracks a lone push
  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue fill level lost a push");
`endif

endmodule

// ----- rtl/rpf_back.sv -----
// Back end: turns queued items into result fields and holds them in the output register.
module rpf_back import rpf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  beat_ctrl_t            head_ctrl,
  input  logic [DATA_WIDTH-1:0] head_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_net_taken,
  output logic                  out_local_taken,
  output logic                  out_update_valid,
  output logic [DATA_WIDTH-1:0] out_update_data,
  output logic                  out_update_last,
  output logic [KEEP_W-1:0]     out_update_keep,
  output logic [DEST_W-1:0]     out_update_dest,
  output logic                  out_out_valid,
  output logic [DATA_WIDTH-1:0] out_out_data,
  output logic                  out_out_last,
  output logic [KEEP_W-1:0]     out_out_keep,
  output logic [DEST_W-1:0]     out_out_dest
);

  logic                  valid_r, valid_nxt;
  logic                  net_taken_r, net_taken_nxt;
  logic                  local_taken_r, local_taken_nxt;
  logic                  upd_valid_r, upd_valid_nxt;
  logic [DATA_WIDTH-1:0] upd_data_r, upd_data_nxt;
  logic                  upd_last_r, upd_last_nxt;
  logic [KEEP_W-1:0]     upd_keep_r, upd_keep_nxt;
  logic [DEST_W-1:0]     upd_dest_r, upd_dest_nxt;
  logic                  ring_valid_r, ring_valid_nxt;
  logic [DATA_WIDTH-1:0] ring_data_r, ring_data_nxt;
  logic                  ring_last_r, ring_last_nxt;
  logic [KEEP_W-1:0]     ring_keep_r, ring_keep_nxt;
  logic [DEST_W-1:0]     ring_dest_r, ring_dest_nxt;
  logic                  load;

  // Load a new item whenever the output register is free or being taken
  assign load = !q_empty && (!valid_r || !out_stall);
  assign pop  = load;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Format the head item; unused ports stay zero
  always_comb begin
    net_taken_nxt   = 1'b0;
    local_taken_nxt = 1'b0;
    upd_valid_nxt   = 1'b0;
    upd_data_nxt    = '0;
    upd_last_nxt    = 1'b0;
    upd_keep_nxt    = '0;
    upd_dest_nxt    = '0;
    ring_valid_nxt  = 1'b0;
    ring_data_nxt   = '0;
    ring_last_nxt   = 1'b0;
    ring_keep_nxt   = '0;
    ring_dest_nxt   = '0;
    case (head_ctrl.cls)
      CLS_OWN, CLS_FWD: begin
        net_taken_nxt = 1'b1;
        upd_valid_nxt = 1'b1;
        upd_data_nxt  = head_data;
        upd_last_nxt  = head_ctrl.last;
        upd_keep_nxt  = head_ctrl.keep;
        upd_dest_nxt  = head_ctrl.dest;
        if (head_ctrl.cls == CLS_FWD) begin
          ring_valid_nxt = 1'b1;
          ring_data_nxt  = head_data;
          ring_last_nxt  = head_ctrl.last;
          ring_keep_nxt  = KEEP_ALL;
          ring_dest_nxt  = FWD_DEST;
        end
      end
      CLS_LOCAL: begin
        local_taken_nxt = 1'b1;
        ring_valid_nxt  = 1'b1;
        ring_data_nxt   = head_data;
        ring_last_nxt   = head_ctrl.last;
        ring_keep_nxt   = head_ctrl.keep;
        ring_dest_nxt   = head_ctrl.dest;
      end
      default: begin
        net_taken_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (load) begin
      net_taken_r   <= net_taken_nxt;
      local_taken_r <= local_taken_nxt;
      upd_valid_r   <= upd_valid_nxt;
      upd_data_r    <= upd_data_nxt;
      upd_last_r    <= upd_last_nxt;
      upd_keep_r    <= upd_keep_nxt;
      upd_dest_r    <= upd_dest_nxt;
      ring_valid_r  <= ring_valid_nxt;
      ring_data_r   <= ring_data_nxt;
      ring_last_r   <= ring_last_nxt;
      ring_keep_r   <= ring_keep_nxt;
      ring_dest_r   <= ring_dest_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_net_taken    = net_taken_r;
  assign out_local_taken  = local_taken_r;
  assign out_update_valid = upd_valid_r;
  assign out_update_data  = upd_data_r;
  assign out_update_last  = upd_last_r;
  assign out_update_keep  = upd_keep_r;
  assign out_update_dest  = upd_dest_r;
  assign out_out_valid    = ring_valid_r;
  assign out_out_data     = ring_data_r;
  assign out_out_last     = ring_last_r;
  assign out_out_keep     = ring_keep_r;
  assign out_out_dest     = ring_dest_r;

endmodule

// ----- test/ring_packet_forwarder_test.sv -----
// Self-checking bench for ring_packet_forwarder: directed rows, then random packets per send limit.
module ring_packet_forwarder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpf_pkg::*;

  localparam int unsigned DW          = DATA_WIDTH_DEF;
  localparam int unsigned IDW         = NODE_ID_BITS_DEF;
  localparam int unsigned PHASE_ITEMS = 255;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_AFTER  = 600;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 4;

  // Packet phase of the node, as tracked by the bench
  typedef enum logic [1:0] {
    PH_FIRST,    // waiting for a first beat
    PH_OWN,      // rest of a returned own packet, dropped
    PH_FOREIGN,  // rest of a foreign packet, forwarded
    PH_LOCAL     // rest of a local packet being sent
  } fwd_phase_t;

  // One offered pair of beats
  typedef struct packed {
    logic              net_valid;
    logic [DW-1:0]     net_data;
    logic              net_last;
    logic [KEEP_W-1:0] net_keep;
    logic [DEST_W-1:0] net_dest;
    logic              local_valid;
    logic [DW-1:0]     local_data;
    logic              local_last;
    logic [KEEP_W-1:0] local_keep;
    logic [DEST_W-1:0] local_dest;
  } ring_beat_t;

  // What the node reports for one item
  typedef struct packed {
    logic              net_taken;
    logic              local_taken;
    logic              upd_valid;
    logic [DW-1:0]     upd_data;
    logic              upd_last;
    logic [KEEP_W-1:0] upd_keep;
    logic [DEST_W-1:0] upd_dest;
    logic              ring_valid;
    logic [DW-1:0]     ring_data;
    logic              ring_last;
    logic [KEEP_W-1:0] ring_keep;
    logic [DEST_W-1:0] ring_dest;
  } node_result_t;

  typedef struct packed {
    ring_beat_t   stim;
    logic         typed;  // res holds the hand-written result
    node_result_t res;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_wr_en      = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wr_data    = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic                  in_net_valid   = 1'b0;
  logic [DW-1:0]         in_net_data    = '0;
  logic                  in_net_last    = 1'b0;
  logic [KEEP_W-1:0]     in_net_keep    = '0;
  logic [DEST_W-1:0]     in_net_dest    = '0;
  logic                  in_local_valid = 1'b0;
  logic [DW-1:0]         in_local_data  = '0;
  logic                  in_local_last  = 1'b0;
  logic [KEEP_W-1:0]     in_local_keep  = '0;
  logic [DEST_W-1:0]     in_local_dest  = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic                  out_net_taken;
  logic                  out_local_taken;
  logic                  out_update_valid;
  logic [DW-1:0]         out_update_data;
  logic                  out_update_last;
  logic [KEEP_W-1:0]     out_update_keep;
  logic [DEST_W-1:0]     out_update_dest;
  logic                  out_out_valid;
  logic [DW-1:0]         out_out_data;
  logic                  out_out_last;
  logic [KEEP_W-1:0]     out_out_keep;
  logic [DEST_W-1:0]     out_out_dest;

  // Bench copy of the node state
  fwd_phase_t         phase_q;
  logic [IDW-1:0]     node_id;
  logic [COUNT_W-1:0] in_flight;
  logic [LIMIT_W-1:0] send_limit;

  node_result_t pending_results[$];
  node_result_t got_exp;
  int unsigned  errors         = 0;
  int unsigned  accepted_items = 0;
  int unsigned  cycles         = 0;

  ring_packet_forwarder u_top (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ring_packet_forwarder regression: fail");
      $finish;
    end
  end

  // Advance the bench state by one item and return the node's report
  function automatic node_result_t forward_step(input ring_beat_t b);
    node_result_t r;
    logic fwd, snd;
    r   = '0;
    fwd = 1'b0;
    snd = 1'b0;
    if (b.net_valid && phase_q != PH_LOCAL) begin
      r.net_taken = 1'b1;
      r.upd_valid = 1'b1;
      r.upd_data  = b.net_data;
      r.upd_last  = b.net_last;
      r.upd_keep  = b.net_keep;
      r.upd_dest  = b.net_dest;
    end
    case (phase_q)
      PH_FIRST: begin
        if (b.net_valid) begin
          // a packet carrying our id has come full circle
          if (b.net_data[IDW-1:0] == node_id) begin
            if (in_flight != '0) in_flight = in_flight - 1'b1;
            phase_q = PH_OWN;
          end else begin
            fwd     = 1'b1;
            phase_q = PH_FOREIGN;
          end
        end else if (b.local_valid && in_flight < send_limit) begin
          snd     = 1'b1;
          node_id = b.local_data[IDW-1:0];
          if (in_flight != COUNT_MAX) in_flight = in_flight + 1'b1;
          phase_q = PH_LOCAL;
        end
      end
      PH_OWN: begin
        if (b.net_valid && b.net_last) phase_q = PH_FIRST;
      end
      PH_FOREIGN: begin
        if (b.net_valid) begin
          fwd = 1'b1;
          if (b.net_last) phase_q = PH_FIRST;
        end
      end
      default: begin
        if (b.local_valid) begin
          snd = 1'b1;
          if (b.local_last) phase_q = PH_FIRST;
        end
      end
    endcase
    if (fwd) begin
      r.ring_valid = 1'b1;
      r.ring_data  = b.net_data;
      r.ring_last  = b.net_last;
      r.ring_keep  = KEEP_ALL;
      r.ring_dest  = FWD_DEST;
    end
    if (snd) begin
      r.local_taken = 1'b1;
      r.ring_valid  = 1'b1;
      r.ring_data   = b.local_data;
      r.ring_last   = b.local_last;
      r.ring_keep   = b.local_keep;
      r.ring_dest   = b.local_dest;
    end
    return r;
  endfunction

  // Random beats shaped by the current phase: mostly well-formed packets
  function automatic ring_beat_t pick_beat();
    ring_beat_t b;
    int unsigned r;
    b.net_valid   = 1'($urandom_range(0, 1));
    b.net_data    = {$urandom, $urandom};
    b.net_last    = 1'($urandom_range(0, 1));
    b.net_keep    = 8'($urandom);
    b.net_dest    = 8'($urandom);
    b.local_valid = 1'($urandom_range(0, 1));
    b.local_data  = {$urandom, $urandom};
    b.local_last  = 1'($urandom_range(0, 1));
    b.local_keep  = 8'($urandom);
    b.local_dest  = 8'($urandom);
    r = $urandom_range(0, 99);
    case (phase_q)
      PH_FIRST: begin
        if (r < 35) begin
          b.net_valid = 1'b1;
        end else if (r < 55) begin
          // returning own packet
          b.net_valid          = 1'b1;
          b.net_data[IDW-1:0] = node_id;
        end else if (r < 90) begin
          b.net_valid   = 1'b0;
          b.local_valid = 1'b1;
          if ($urandom_range(0, 7) == 0) b.local_data[IDW-1:0] = '1;
        end
      end
      PH_OWN, PH_FOREIGN: begin
        if (r < 85) begin
          b.net_valid = 1'b1;
          b.net_last  = ($urandom_range(0, 2) == 0);
        end
      end
      default: begin
        if (r < 85) begin
          b.local_valid = 1'b1;
          b.local_last  = ($urandom_range(0, 2) == 0);
        end
      end
    endcase
    return b;
  endfunction

  // Offer one item, wait for it to be taken, record its expected result
  task automatic offer(input ring_beat_t b, input logic typed, input node_result_t typed_res);
    node_result_t r;
    in_valid       <= 1'b1;
    in_net_valid   <= b.net_valid;
    in_net_data    <= b.net_data;
    in_net_last    <= b.net_last;
    in_net_keep    <= b.net_keep;
    in_net_dest    <= b.net_dest;
    in_local_valid <= b.local_valid;
    in_local_data  <= b.local_data;
    in_local_last  <= b.local_last;
    in_local_keep  <= b.local_keep;
    in_local_dest  <= b.local_dest;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = forward_step(b);
    pending_results.push_back(typed ? typed_res : r);
    accepted_items++;
  endtask

  // Sender gap after an item: none in calm stretches, mostly short otherwise
  task automatic idle_gap();
    int unsigned r, g;
    r = $urandom_range(0, 99);
    if (accepted_items % 128 < 24 || r < 65) g = 0;
    else if (r < 92) g = $urandom_range(1, 3);
    else g = $urandom_range(8, 40);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    send_limit = v;
  endtask

  function automatic void match_field(input string name, input logic [DW-1:0] e,
                                      input logic [DW-1:0] a);
    if (a !== e) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        got_exp = pending_results.pop_front();
        match_field("net_taken", DW'(got_exp.net_taken), DW'(out_net_taken));
        match_field("local_taken", DW'(got_exp.local_taken), DW'(out_local_taken));
        match_field("update_valid", DW'(got_exp.upd_valid), DW'(out_update_valid));
        match_field("update_data", got_exp.upd_data, out_update_data);
        match_field("update_last", DW'(got_exp.upd_last), DW'(out_update_last));
        match_field("update_keep", DW'(got_exp.upd_keep), DW'(out_update_keep));
        match_field("update_dest", DW'(got_exp.upd_dest), DW'(out_update_dest));
        match_field("out_valid", DW'(got_exp.ring_valid), DW'(out_out_valid));
        match_field("out_data", got_exp.ring_data, out_out_data);
        match_field("out_last", DW'(got_exp.ring_last), DW'(out_out_last));
        match_field("out_keep", DW'(got_exp.ring_keep), DW'(out_out_keep));
        match_field("out_dest", DW'(got_exp.ring_dest), DW'(out_out_dest));
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off to fill the block
  initial begin : receiver
    int unsigned n;
    bit held;
    held = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && accepted_items >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= 1'b0;
      n = (cycles % 1024 < 200) ? 60 : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    dir_row_t           rows[$];
    ring_beat_t         b;
    int unsigned        n;
    logic [LIMIT_W-1:0] limits[5];

    phase_q    = PH_FIRST;
    node_id    = '1;
    in_flight  = '0;
    send_limit = SEND_LIMIT_RST;
    limits     = '{8'd255, 8'd0, 8'd1, 8'd4, 8'($urandom_range(2, 254))};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing offered: all-zero report
    rows.push_back('{'{1'b0, 64'h0, 1'b0, 8'h00, 8'h00, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b1, '{1'b0, 1'b0, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00}});
    // reset id is all ones: own packet returns, count holds at zero, network wins over local
    rows.push_back('{'{1'b1, '1, 1'b0, 8'h00, 8'hFF, 1'b1, 64'h0, 1'b1, 8'hFF, 8'h00},
      1'b1, '{1'b1, 1'b0, 1'b1, '1, 1'b0, 8'h00, 8'hFF, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00}});
    // local beat ignored during an own packet
    rows.push_back('{'{1'b0, 64'h0, 1'b0, 8'h00, 8'h00, 1'b1, 64'h5, 1'b1, 8'h0F, 8'h03},
      1'b0, '0});
    rows.push_back('{'{1'b1, 64'h0, 1'b1, 8'hFF, 8'h00, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b0, '0});
    // foreign single-beat first: forwarded with keep all ones, dest 1
    rows.push_back('{'{1'b1, 64'h0, 1'b1, 8'h5A, 8'h77, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b1, '{1'b1, 1'b0, 1'b1, 64'h0, 1'b1, 8'h5A, 8'h77, 1'b1, 64'h0, 1'b1, 8'hFF, 8'h01}});
    rows.push_back('{'{1'b1, '1, 1'b1, 8'h00, 8'hFF, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b0, '0});
    // local send: passes through, id becomes 1
    rows.push_back('{'{1'b0, 64'h0, 1'b0, 8'h00, 8'h00,
      1'b1, 64'h1234_5678_0000_0001, 1'b0, 8'h0F, 8'h22}, 1'b1,
      '{1'b0, 1'b1, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00,
        1'b1, 64'h1234_5678_0000_0001, 1'b0, 8'h0F, 8'h22}});
    // network beat not taken while sending
    rows.push_back('{'{1'b1, 64'h1, 1'b1, 8'hAA, 8'h55, 1'b1, '1, 1'b1, 8'hFF, 8'hFF},
      1'b0, '0});
    rows.push_back('{'{1'b1, 64'hABCD_0000_0000_0001, 1'b0, 8'h33, 8'h44,
      1'b1, 64'h0, 1'b0, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{1'b1, 64'h0, 1'b1, 8'h00, 8'h00, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b0, '0});
    // single-beat local first still enters the sending phase
    rows.push_back('{'{1'b0, 64'h0, 1'b0, 8'h00, 8'h00, 1'b1, 64'h0, 1'b1, 8'h00, 8'h00},
      1'b0, '0});
    rows.push_back('{'{1'b1, '1, 1'b1, 8'hFF, 8'hFF, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b0, '0});
    rows.push_back('{'{1'b0, 64'h0, 1'b0, 8'h00, 8'h00, 1'b1, '1, 1'b1, 8'h81, 8'h7E},
      1'b0, '0});
    // id is now zero: single-beat own packet, then its tail
    rows.push_back('{'{1'b1, 64'h0000_0001_0000_0000, 1'b1, 8'h01, 8'h80,
      1'b0, 64'h0, 1'b0, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{1'b1, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 8'hC3, 8'h3C,
      1'b1, 64'h0, 1'b0, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{1'b1, 64'h0, 1'b1, 8'h00, 8'h00, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b0, '0});
    // foreign packet with all-ones id, gaps and a local beat inside it
    rows.push_back('{'{1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0, 8'h12, 8'h34,
      1'b0, 64'h0, 1'b0, 8'h00, 8'h00}, 1'b0, '0});
    rows.push_back('{'{1'b0, '1, 1'b1, 8'hFF, 8'hFF, 1'b0, 64'h0, 1'b0, 8'h00, 8'h00},
      1'b0, '0});
    rows.push_back('{'{1'b0, 64'h0, 1'b0, 8'h00, 8'h00, 1'b1, '1, 1'b1, 8'hFF, 8'hFF},
      1'b0, '0});
    rows.push_back('{'{1'b1, 64'h8000_0000_0000_0000, 1'b1, 8'h80, 8'h01,
      1'b1, 64'h0, 1'b0, 8'h00, 8'h00}, 1'b0, '0});

    foreach (rows[i]) begin
      offer(rows[i].stim, rows[i].typed, rows[i].res);
      idle_gap();
    end

    // random packets under the reset limit, then under each written limit
    for (int p = 0; p <= 5; p++) begin
      if (p > 0) write_limit(limits[p-1]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        b = pick_beat();
        offer(b, 1'b0, '0);
        n++;
        idle_gap();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ring_packet_forwarder regression: pass");
    end else begin
      $display("ring_packet_forwarder regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rpf_pkg.sv
rtl/rpf_front.sv
rtl/rpf_queue.sv
rtl/rpf_back.sv
rtl/ring_packet_forwarder.sv
test/ring_packet_forwarder_test.sv
